/* hdl/sdff_pkg.sv */
// Shared constants and types for the signed decimal field formatter.
// Used by sdff_b2d and signed_decimal_field_formatter_unit; no dependencies.
package sdff_pkg;

	localparam int VALUE_W   = 32;
	localparam int FIELD_W   = 6;
	localparam int NUM_DIG   = 10;
	localparam int BCD_W     = 4 * NUM_DIG;
	localparam int ND_W      = 4;
	localparam int BITCNT_W  = 5;
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 8;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// converter status toward the sequencer
	typedef struct packed {
		logic            done;
		logic [3:0]      top_digit;
		logic [ND_W-1:0] nd;
	} b2d_stat_t;

endpackage

/* hdl/sdff_b2d.sv */
// Bit-serial binary to BCD converter (shift and add 3), then leading-zero strip.
// Depends on sdff_pkg. Digits are shifted out most significant first.
module sdff_b2d
	import sdff_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] mag,
	input  logic               next_digit,
	output b2d_stat_t          stat
);

	typedef enum logic [1:0] {C_IDLE, C_SHIFT, C_NORM, C_DONE} cstate_t;

	cstate_t              state_q;
	logic [VALUE_W-1:0]   bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BITCNT_W-1:0]  cnt_q;
	logic [ND_W-1:0]      nd_q;
	logic [BCD_W-1:0]     adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int d = 0; d < NUM_DIG; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5)
				adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			else
				adj[4*d +: 4] = bcd_q[4*d +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			nd_q    <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						bin_q   <= mag;
						bcd_q   <= '0;
						cnt_q   <= '0;
						state_q <= C_SHIFT;
					end
				end
				C_SHIFT: begin
					bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
					bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == BITCNT_W'(VALUE_W - 1)) begin
						nd_q    <= ND_W'(NUM_DIG);
						state_q <= C_NORM;
					end
				end
				C_NORM: begin
					// drop leading zero digits; zero magnitude ends with no digits
					if (bcd_q[BCD_W-1 -: 4] != 4'd0 || nd_q == '0) begin
						state_q <= C_DONE;
					end else begin
						bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
						nd_q  <= nd_q - 1'b1;
					end
				end
				C_DONE: begin
					if (start) begin
						bin_q   <= mag;
						bcd_q   <= '0;
						cnt_q   <= '0;
						state_q <= C_SHIFT;
					end else if (next_digit) begin
						bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign stat.done      = (state_q == C_DONE);
	assign stat.top_digit = bcd_q[BCD_W-1 -: 4];
	assign stat.nd        = nd_q;

endmodule

/* hdl/signed_decimal_field_formatter_unit.sv */
// Signed decimal field formatter: printf %d text, one ASCII character per output transfer.
// Each request is converted by sdff_b2d (bit-serial conversion, then leading-zero strip),
// sized in T_SIZE and sent from T_EMIT through the registered output. A new request is
// taken only in idle, once the previous field of n characters (n at most MAX_FIELD + 1)
// has been sent at one character per cycle while the output does not stall.
// Reset (arst_n, async low) empties the output register and returns to idle.
module signed_decimal_field_formatter_unit
	import sdff_pkg::*;
#(
	parameter int MAX_FIELD = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// value[31:0], left_align, zero_pad, plus_flag, space_flag, has_precision,
	// precision[5:0], field_width[5:0], zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// char_out[7:0]
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	localparam int CW = $clog2(MAX_FIELD + 2);

	typedef enum logic [1:0] {T_IDLE, T_CONV, T_SIZE, T_EMIT} tstate_t;

	tstate_t         state_q;
	logic            left_q, zpad_q, hasp_q;
	logic [FIELD_W-1:0] prec_q, width_q;
	logic            sign_q;
	logic [7:0]      sign_ch_q;
	logic [CW-1:0]   padl_q, zeros_q, padt_q, rem_q;
	logic [ND_W-1:0] nd_q;
	logic            m_tvalid_q, m_tlast_q;
	logic [7:0]      m_tdata_q;

	logic               accept;
	logic [VALUE_W-1:0] raw, mag;
	logic               neg, plus_f, space_f;
	logic               conv_start, next_digit, fire;
	b2d_stat_t          stat;

	logic [CW-1:0] prec_e, width_e, nd_e, zer, total, pad, rem_n;
	logic          sign_len;
	logic [7:0]    ch;

	assign s_tready = (state_q == T_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign raw      = s_tdata[VALUE_W-1:0];
	assign neg      = raw[VALUE_W-1];
	assign mag      = neg ? (VALUE_W'(0) - raw) : raw;
	assign plus_f   = s_tdata[34];
	assign space_f  = s_tdata[35];
	assign conv_start = accept;

	sdff_b2d u_b2d (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (conv_start),
		.mag        (mag),
		.next_digit (next_digit),
		.stat       (stat)
	);

	// field sizing from the stripped digit count
	always_comb begin
		if (!hasp_q)
			prec_e = CW'(1);
		else if ({1'b0, prec_q} > 7'(MAX_FIELD))
			prec_e = CW'(MAX_FIELD);
		else
			prec_e = CW'(prec_q);
		if ({1'b0, width_q} > 7'(MAX_FIELD))
			width_e = CW'(MAX_FIELD);
		else
			width_e = CW'(width_q);
		nd_e     = CW'(stat.nd);
		sign_len = sign_q;
		zer      = (prec_e > nd_e) ? (prec_e - nd_e) : '0;
		total    = zer + nd_e + CW'(sign_len);
		pad      = (width_e > total) ? (width_e - total) : '0;
		rem_n    = total + pad;
	end

	assign fire       = (state_q == T_EMIT) && (!m_tvalid_q || m_tready);
	assign next_digit = fire && padl_q == '0 && !sign_q && zeros_q == '0 && nd_q != '0;

	always_comb begin
		if (padl_q != '0)
			ch = CH_SPACE;
		else if (sign_q)
			ch = sign_ch_q;
		else if (zeros_q != '0)
			ch = CH_ZERO;
		else if (nd_q != '0)
			ch = CH_ZERO | {4'd0, stat.top_digit};
		else
			ch = CH_SPACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			m_tvalid_q <= 1'b0;
			sign_q     <= 1'b0;
			padl_q     <= '0;
			zeros_q    <= '0;
			padt_q     <= '0;
			rem_q      <= '0;
			nd_q       <= '0;
		end else begin
			if (fire)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						left_q  <= s_tdata[32];
						zpad_q  <= s_tdata[33];
						hasp_q  <= s_tdata[36];
						prec_q  <= s_tdata[42:37];
						width_q <= s_tdata[48:43];
						sign_q  <= neg || plus_f || space_f;
						if (neg)
							sign_ch_q <= CH_MINUS;
						else if (plus_f)
							sign_ch_q <= CH_PLUS;
						else
							sign_ch_q <= CH_SPACE;
						state_q <= T_CONV;
					end
				end
				T_CONV: begin
					if (stat.done)
						state_q <= T_SIZE;
				end
				T_SIZE: begin
					nd_q  <= stat.nd;
					rem_q <= rem_n;
					if (!left_q && zpad_q && !hasp_q) begin
						zeros_q <= zer + pad;
						padl_q  <= '0;
						padt_q  <= '0;
					end else if (left_q) begin
						zeros_q <= zer;
						padl_q  <= '0;
						padt_q  <= pad;
					end else begin
						zeros_q <= zer;
						padl_q  <= pad;
						padt_q  <= '0;
					end
					// empty field: nothing to send
					state_q <= (rem_n == '0) ? T_IDLE : T_EMIT;
				end
				T_EMIT: begin
					if (fire) begin
						m_tdata_q  <= ch;
						m_tlast_q  <= (rem_q == CW'(1));
						rem_q      <= rem_q - 1'b1;
						if (padl_q != '0)
							padl_q <= padl_q - 1'b1;
						else if (sign_q)
							sign_q <= 1'b0;
						else if (zeros_q != '0)
							zeros_q <= zeros_q - 1'b1;
						else if (nd_q != '0)
							nd_q <= nd_q - 1'b1;
						else if (padt_q != '0)
							padt_q <= padt_q - 1'b1;
						if (rem_q == CW'(1))
							state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

/* verif/tb.sv */
// Testbench for signed_decimal_field_formatter_unit: streams printf %d requests
// and checks every emitted character and its tlast against a built-in predictor.
// Depends on sdff_pkg and the RTL top level only.
`timescale 1ns / 1ps

localparam int FIELD_MAX = 32;

typedef struct {
	logic [7:0] ch;
	logic       last_flag;
} field_char_t;

class decimal_field_board;
	field_char_t pending_chars[$];
	int          mismatch_count;
	int          chars_checked;

	function new();
		mismatch_count = 0;
		chars_checked = 0;
	endfunction

	function int unsigned clip_field(logic [5:0] v);
		return (v > FIELD_MAX) ? FIELD_MAX : int'(v);
	endfunction

	// builds the expected text of one accepted request
	function void note_request(logic [sdff_pkg::S_TDATA_W-1:0] req);
		logic [31:0] raw, mag;
		logic neg, left, zpad, plus, space, hasp;
		int unsigned prec, width, nd, zeros, total, pad, sign_len;
		logic [7:0] sign_ch;
		logic [7:0] digs[12];
		logic [7:0] text[$];
		raw = req[31:0];
		left = req[32];
		zpad = req[33];
		plus = req[34];
		space = req[35];
		hasp = req[36];
		prec = hasp ? clip_field(req[42:37]) : 1;
		width = clip_field(req[48:43]);
		neg = raw[31];
		mag = neg ? (32'd0 - raw) : raw;
		nd = 0;
		while (mag != 0) begin
			digs[nd] = sdff_pkg::CH_ZERO + 8'(mag % 10);
			mag = mag / 10;
			nd++;
		end
		sign_ch = 8'h00;
		if (neg)
			sign_ch = sdff_pkg::CH_MINUS;
		else if (plus)
			sign_ch = sdff_pkg::CH_PLUS;
		else if (space)
			sign_ch = sdff_pkg::CH_SPACE;
		sign_len = (sign_ch != 8'h00) ? 1 : 0;
		zeros = (prec > nd) ? prec - nd : 0;
		total = sign_len + zeros + nd;
		pad = (width > total) ? width - total : 0;
		// zero padding only without precision and without left alignment
		if (!left && zpad && !hasp) begin
			zeros += pad;
			pad = 0;
		end
		if (!left)
			repeat (pad) text.push_back(sdff_pkg::CH_SPACE);
		if (sign_len != 0)
			text.push_back(sign_ch);
		repeat (zeros) text.push_back(sdff_pkg::CH_ZERO);
		for (int i = int'(nd) - 1; i >= 0; i--)
			text.push_back(digs[i]);
		if (left)
			repeat (pad) text.push_back(sdff_pkg::CH_SPACE);
		foreach (text[i])
			pending_chars.push_back('{ch: text[i], last_flag: (i == text.size() - 1)});
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH char %0d: %s", chars_checked, msg);
		mismatch_count++;
	endtask

	task check_char(logic [7:0] ch, logic last_flag);
		field_char_t want;
		if (pending_chars.size() == 0) begin
			report_mismatch($sformatf("unexpected char 0x%02h tlast %b", ch, last_flag));
			chars_checked++;
			return;
		end
		want = pending_chars.pop_front();
		if (ch !== want.ch)
			report_mismatch($sformatf("char 0x%02h, want 0x%02h", ch, want.ch));
		if (last_flag !== want.last_flag)
			report_mismatch($sformatf("tlast %b, want %b", last_flag, want.last_flag));
		chars_checked++;
	endtask
endclass

module tb;
	import sdff_pkg::*;

	localparam int RANDOM_REQS = 300;
	localparam int SETTLE_CYCLES = 64;
	localparam int STALL_LIMIT = 2000;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;

	decimal_field_board   board;
	logic [S_TDATA_W-1:0] requests[$];
	int                   stuck_cycles = 0;
	int                   ready_mode = 0;
	int                   ready_left = 0;

	signed_decimal_field_formatter_unit #(.MAX_FIELD(FIELD_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always #6 clk = ~clk;

	function automatic logic [S_TDATA_W-1:0] pack_req(logic [31:0] v, bit la, bit zp,
			bit pl, bit sp, bit hp, logic [5:0] pr, logic [5:0] wd);
		return {7'd0, wd, pr, hp, sp, pl, zp, la, v};
	endfunction

	function automatic logic [S_TDATA_W-1:0] random_req();
		logic [31:0] v;
		logic [5:0]  pr, wd;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = 32'($urandom_range(0, 40)) - 32'd20;
			2: begin
				case ($urandom_range(0, 4))
					0: v = INT_MIN;
					1: v = INT_MAX;
					2: v = 32'd0;
					3: v = 32'hFFFF_FFFF;
					default: v = INT_MIN + 32'd1;
				endcase
			end
			3: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1) == 1)
					v = 32'd0 - v;
			end
			default: begin
				v = 32'($urandom_range(0, 99999));
				if ($urandom_range(0, 1) == 1)
					v = 32'd0 - v;
			end
		endcase
		pr = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 12)) : 6'($urandom_range(0, 63));
		case ($urandom_range(0, 19))
			0, 1, 2: wd = 6'($urandom_range(0, 63));
			3, 4, 5, 6, 7: wd = 6'($urandom_range(13, 33));
			default: wd = 6'($urandom_range(0, 12));
		endcase
		return pack_req(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), pr, wd);
	endfunction

	// holds off requests until all text is out and the converter has gone quiet
	task wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (board.pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver: switches between always ready, coin flips, periodic and long stalls
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(16, 96);
		end else begin
			ready_left--;
		end
		case (ready_mode)
			0: m_tready = 1'b1;
			1: m_tready = 1'($urandom_range(0, 1));
			2: m_tready = (ready_left % 4 != 0);
			default: if ($urandom_range(0, 5) == 0) m_tready = ~m_tready;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_request(s_tdata);
			if (m_tvalid && m_tready)
				board.check_char(m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("watchdog: no request or character moved for %0d cycles", STALL_LIMIT);
				$display("signed_decimal_field_formatter_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		int idx;
		int burst;
		int gap;
		int pause_at;
		board = new();

		// empty field, sign on zero, precision 0, extremes, flag interplay
		requests.push_back(pack_req(32'd0, 0, 0, 0, 0, 1, 6'd0, 6'd0));
		requests.push_back(pack_req(32'd0, 0, 0, 1, 0, 1, 6'd0, 6'd0));
		requests.push_back(pack_req(32'd0, 0, 0, 0, 1, 1, 6'd0, 6'd3));
		requests.push_back(pack_req(32'd0, 0, 0, 0, 0, 0, 6'd0, 6'd0));
		requests.push_back(pack_req(INT_MIN, 0, 0, 0, 0, 0, 6'd0, 6'd0));
		requests.push_back(pack_req(INT_MAX, 0, 0, 1, 0, 0, 6'd0, 6'd0));
		requests.push_back(pack_req(32'hFFFF_FFFF, 0, 1, 0, 0, 0, 6'd0, 6'd8));
		requests.push_back(pack_req(32'd42, 0, 1, 1, 1, 0, 6'd0, 6'd6));
		requests.push_back(pack_req(32'd42, 1, 1, 0, 1, 0, 6'd0, 6'd6));
		requests.push_back(pack_req(32'd0 - 32'd42, 0, 1, 0, 0, 1, 6'd4, 6'd8));
		requests.push_back(pack_req(32'd123, 0, 0, 0, 0, 1, 6'd63, 6'd0));
		requests.push_back(pack_req(32'd123, 1, 0, 0, 0, 0, 6'd0, 6'd63));
		requests.push_back(pack_req(INT_MIN, 0, 0, 0, 0, 1, 6'd40, 6'd63));
		requests.push_back(pack_req(INT_MAX, 0, 1, 1, 0, 0, 6'd0, 6'd63));
		requests.push_back(pack_req(32'd7, 0, 0, 0, 0, 1, 6'd0, 6'd0));
		requests.push_back(pack_req(32'd12345, 0, 0, 0, 0, 0, 6'd0, 6'd3));
		requests.push_back(pack_req(32'd0 - 32'd987654321, 1, 0, 0, 0, 1, 6'd12, 6'd20));
		requests.push_back(pack_req(32'd0, 1, 0, 0, 0, 1, 6'd0, 6'd5));
		requests.push_back(pack_req(32'd1, 0, 0, 0, 1, 0, 6'd0, 6'd0));
		requests.push_back(pack_req(INT_MIN + 32'd1, 0, 1, 0, 0, 0, 6'd0, 6'd33));
		requests.push_back(pack_req(32'd1000000000, 0, 0, 0, 0, 1, 6'd10, 6'd11));
		requests.push_back(pack_req(32'd0, 0, 1, 0, 0, 0, 6'd0, 6'd32));
		pause_at = requests.size() + RANDOM_REQS / 2;
		repeat (RANDOM_REQS) requests.push_back(random_req());

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idx = 0;
		while (idx < requests.size()) begin
			burst = $urandom_range(1, 8);
			while (burst > 0 && idx < requests.size()) begin
				if (idx == pause_at)
					wait_drained();
				@(negedge clk);
				s_tvalid = 1'b1;
				s_tdata = requests[idx];
				do @(posedge clk); while (s_tready !== 1'b1);
				idx++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end

		wait_drained();
		if (board.mismatch_count == 0)
			$display("signed_decimal_field_formatter_unit verification clean");
		else
			$display("signed_decimal_field_formatter_unit verification failed");
		$finish;
	end

endmodule
